[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define MIP_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("mip assertion failed");

// Implication checked in the next cycle, disabled during reset.
`define MIP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("mip assertion failed");

`endif

[sv/mip_pkg.sv]
// ----------------------------------------------------------------------------
// Instruction predecoder package
// Operand formats, format ROM, configuration register indexes and the
// records passed from the parser to the decode stage and out of it.
// ----------------------------------------------------------------------------
package mip_pkg;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_HIGH_FIRST = 1'd1;

  localparam logic [2:0] FMT_NONE  = 3'd0;
  localparam logic [2:0] FMT_SBYTE = 3'd1;
  localparam logic [2:0] FMT_BYTE2 = 3'd2;
  localparam logic [2:0] FMT_SWORD = 3'd3;
  localparam logic [2:0] FMT_WORD2 = 3'd4;
  localparam logic [2:0] FMT_BWORD = 3'd5;

  localparam logic [7:0] OP_JUMP_BACK_0 = 8'o034;
  localparam logic [7:0] OP_JUMP_BACK_1 = 8'o035;
  localparam logic [7:0] OP_JUMP_FWD_0  = 8'o030;
  localparam logic [7:0] OP_JUMP_FWD_1  = 8'o031;
  localparam logic [7:0] OP_JUMP_FWD_2  = 8'o032;
  localparam logic [7:0] OP_JUMP_FWD_3  = 8'o033;
  localparam logic [7:0] OP_JUMP_FWD_4  = 8'o036;
  localparam logic [7:0] OP_JUMP_FWD_5  = 8'o037;
  localparam logic [7:0] OP_FOR1        = 8'o300;
  localparam logic [7:0] OP_FOR2        = 8'o301;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  opcode;
    logic [2:0]  fmt;
    logic [31:0] bytes;
  } mip_instr_t;

  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode;
    logic [2:0]  length;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        has_target;
    logic [15:0] branch_target;
    logic        count_down;
  } mip_result_t;

  function automatic logic [2:0] fmt_rom(input logic [7:0] op);
    logic [2:0] f;
    case (op)
      8'h10, 8'h14, 8'h15, 8'h16, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f,
      8'h20, 8'h21, 8'h30, 8'h31, 8'h40, 8'h41, 8'h50, 8'h51,
      8'h80, 8'h81, 8'h84, 8'h90, 8'h91, 8'h9f,
      8'ha6, 8'ha7, 8'ha8, 8'hae, 8'haf, 8'hb7,
      8'he8, 8'heb, 8'hee, 8'hf0:       f = FMT_SBYTE;
      8'h22, 8'h23, 8'h32, 8'h33, 8'hed: f = FMT_BYTE2;
      8'h12, 8'h17, 8'h18, 8'h19, 8'hc2: f = FMT_SWORD;
      8'h13:                             f = FMT_WORD2;
      8'hc0, 8'hc1:                      f = FMT_BWORD;
      default:                           f = FMT_NONE;
    endcase
    return f;
  endfunction

  function automatic logic [2:0] fmt_bytes(input logic [2:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_SBYTE: n = 3'd1;
      FMT_BYTE2: n = 3'd2;
      FMT_SWORD: n = 3'd2;
      FMT_WORD2: n = 3'd4;
      FMT_BWORD: n = 3'd3;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

[sv/mcode_instruction_predecoder_top.sv]
// ----------------------------------------------------------------------------
// Stack-machine instruction predecoder
// Splits a byte-wide code stream into instructions and reports address,
// opcode, length, operands and branch target of each one.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Carries
//  ---------+------------------------+-------------------------------------
//  input    | in_valid / in_stall    | code_byte, restart
//  output   | out_valid / out_stall  | one transaction per instruction
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One code byte is taken per cycle unless in_stall is high; the last byte
// passes the parser register and then the result register to out_valid.
// The rate is set by the combinational format ROM lookup and 16-bit adds.
// Reset clears the program counter and partial instruction, loads the
// configuration defaults and empties both stages.
// A stall on the output holds the result and backs up into in_stall once
// the parser register is also occupied. Configuration writes are always ready.
module mcode_instruction_predecoder_top import mip_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           code_byte,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          instr_address,
  output logic [7:0]           opcode,
  output logic [2:0]           length,
  output logic [15:0]          operand_a,
  output logic [15:0]          operand_b,
  output logic                 has_target,
  output logic [15:0]          branch_target,
  output logic                 count_down,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic        start_we;
  logic [15:0] start_address;
  logic        word_high_first;
  logic        out_en;
  logic        instr_valid;
  mip_instr_t  instr;
  mip_result_t result;

  assign cfg_ready = 1'b1;
  assign start_we  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address   <= 16'd0;
      word_high_first <= 1'b1;
    end else if (start_we) begin
      case (cfg_index)
        REG_START_ADDRESS:   start_address   <= cfg_data;
        REG_WORD_HIGH_FIRST: word_high_first <= cfg_data[0];
        default: begin
          start_address <= start_address;
        end
      endcase
    end
  end

  mip_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .code_byte     (code_byte),
    .restart       (restart),
    .start_address (start_address),
    .out_en        (out_en),
    .instr_valid   (instr_valid),
    .instr         (instr)
  );

  mip_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .instr_valid     (instr_valid),
    .instr           (instr),
    .word_high_first (word_high_first),
    .out_en          (out_en),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result          (result)
  );

  assign instr_address = result.instr_address;
  assign opcode        = result.opcode;
  assign length        = result.length;
  assign operand_a     = result.operand_a;
  assign operand_b     = result.operand_b;
  assign has_target    = result.has_target;
  assign branch_target = result.branch_target;
  assign count_down    = result.count_down;

endmodule

[sv/mip_parser.sv]
// ----------------------------------------------------------------------------
// Instruction predecoder parser
// Tracks the program counter and the bytes of the current instruction and
// registers a record of each completed instruction.
// ----------------------------------------------------------------------------
module mip_parser import mip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        restart,
  input  logic [15:0] start_address,
  input  logic        out_en,
  output logic        instr_valid,
  output mip_instr_t  instr
);

  logic [15:0] program_counter, program_counter_next;
  logic [7:0]  held_opcode, held_opcode_next;
  logic [2:0]  operand_format, operand_format_next;
  logic [2:0]  bytes_pending, bytes_pending_next;
  logic [31:0] operand_bytes, operand_bytes_next;
  logic [15:0] opcode_address, opcode_address_next;
  logic [2:0]  pend_eff;
  logic [15:0] pc_eff;
  logic        complete;
  logic        accept;
  logic        load_en;

  assign load_en  = !instr_valid || out_en;
  assign in_stall = !load_en;
  assign accept   = in_valid && load_en;

  always_comb begin
    pend_eff             = restart ? 3'd0 : bytes_pending;
    pc_eff               = restart ? start_address : program_counter;
    program_counter_next = pc_eff + 16'd1;
    if (pend_eff == 3'd0) begin
      opcode_address_next = pc_eff;
      held_opcode_next    = code_byte;
      operand_format_next = fmt_rom(code_byte);
      bytes_pending_next  = fmt_bytes(operand_format_next);
      operand_bytes_next  = 32'd0;
      complete            = (bytes_pending_next == 3'd0);
    end else begin
      opcode_address_next = opcode_address;
      held_opcode_next    = held_opcode;
      operand_format_next = operand_format;
      bytes_pending_next  = pend_eff - 3'd1;
      operand_bytes_next  = {operand_bytes[23:0], code_byte};
      complete            = (bytes_pending_next == 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_counter <= 16'd0;
      held_opcode     <= 8'd0;
      operand_format  <= FMT_NONE;
      bytes_pending   <= 3'd0;
      operand_bytes   <= 32'd0;
      opcode_address  <= 16'd0;
      instr_valid     <= 1'b0;
    end else begin
      if (accept) begin
        program_counter <= program_counter_next;
        held_opcode     <= held_opcode_next;
        operand_format  <= operand_format_next;
        bytes_pending   <= bytes_pending_next;
        operand_bytes   <= operand_bytes_next;
        opcode_address  <= opcode_address_next;
      end
      if (load_en) begin
        instr_valid <= accept && complete;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      instr.addr   <= opcode_address_next;
      instr.opcode <= held_opcode_next;
      instr.fmt    <= operand_format_next;
      instr.bytes  <= operand_bytes_next;
    end
  end

endmodule

[sv/mip_decode.sv]
// ----------------------------------------------------------------------------
// Instruction predecoder decode stage
// Assembles the operands of a completed instruction, computes its branch
// target and holds the result for the output channel.
// ----------------------------------------------------------------------------
module mip_decode import mip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  input  mip_instr_t  instr,
  input  logic        word_high_first,
  output logic        out_en,
  output logic        out_valid,
  input  logic        out_stall,
  output mip_result_t result
);

  mip_result_t res_next;
  logic [31:0] r;
  logic [15:0] w_hi, w_lo;
  logic [15:0] a, b;
  logic [15:0] base;

  assign out_en = !out_valid || !out_stall;

  always_comb begin
    r    = instr.bytes;
    w_hi = word_high_first ? r[31:16] : {r[23:16], r[31:24]};
    w_lo = word_high_first ? r[15:0]  : {r[7:0], r[15:8]};
    a    = 16'd0;
    b    = 16'd0;
    case (instr.fmt)
      FMT_SBYTE: a = {{8{r[7]}}, r[7:0]};
      FMT_BYTE2: begin
        a = {8'd0, r[15:8]};
        b = {8'd0, r[7:0]};
      end
      FMT_SWORD: a = w_lo;
      FMT_WORD2: begin
        a = w_hi;
        b = w_lo;
      end
      FMT_BWORD: begin
        a = w_lo;
        b = {8'd0, r[23:16]};
      end
      default: begin
        a = 16'd0;
        b = 16'd0;
      end
    endcase

    base                   = instr.addr + 16'd1;
    res_next.instr_address = instr.addr;
    res_next.opcode        = instr.opcode;
    res_next.length        = fmt_bytes(instr.fmt) + 3'd1;
    res_next.operand_a     = a;
    res_next.operand_b     = b;
    res_next.has_target    = 1'b0;
    res_next.branch_target = 16'd0;
    res_next.count_down    = 1'b0;
    case (instr.opcode)
      OP_JUMP_BACK_0, OP_JUMP_BACK_1: begin
        res_next.has_target    = 1'b1;
        res_next.branch_target = base - a;
      end
      OP_JUMP_FWD_0, OP_JUMP_FWD_1, OP_JUMP_FWD_2, OP_JUMP_FWD_3,
      OP_JUMP_FWD_4, OP_JUMP_FWD_5: begin
        res_next.has_target    = 1'b1;
        res_next.branch_target = base + a;
      end
      OP_FOR1, OP_FOR2: begin
        res_next.has_target    = 1'b1;
        res_next.branch_target = instr.addr + {{8{a[7]}}, a[7:0]} - 16'd2;
        res_next.count_down    = (instr.opcode == OP_FOR1) && (b != 16'd0);
      end
      default: begin
        res_next.has_target = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= instr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      result <= res_next;
    end
  end

endmodule

[sv/mip_checker.sv]
// ----------------------------------------------------------------------------
// Instruction predecoder checker
// Port-level assertions on the output transactions of the predecoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mip_checker import mip_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] instr_address,
  input logic [7:0]  opcode,
  input logic [2:0]  length,
  input logic [15:0] operand_a,
  input logic [15:0] operand_b,
  input logic        has_target,
  input logic [15:0] branch_target,
  input logic        count_down
);

  // A stalled transaction must stay in place with its opcode, address and branch target.
  `MIP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(opcode) && $stable(instr_address) && $stable(branch_target))
  `MIP_ASSERT_NOW(a_len_range, clk, rst, out_valid, length >= 3'd1 && length <= 3'd5)
  `MIP_ASSERT_NOW(a_no_target, clk, rst, out_valid && !has_target, branch_target == 16'd0 && !count_down)
  `MIP_ASSERT_NOW(a_no_operand, clk, rst, out_valid && length == 3'd1, operand_a == 16'd0 && operand_b == 16'd0)

endmodule

bind mcode_instruction_predecoder_top mip_checker u_mip_checker (.*);
